FILE: rtl/core/hsp_pkg.sv
// Shared types and constants for the seven-point heat stencil.
// Used by every module of the block; depends on nothing.
package hsp_pkg;

  localparam int EXT_BITS    = 6;
  localparam int MAX_EXTENT  = 1 << EXT_BITS;
  localparam int SAMPLE_BITS = 32;
  localparam int ADDR_BITS   = 2 * EXT_BITS + 1;
  localparam int STORE_WORDS = 1 << ADDR_BITS;
  localparam int DIFF_BITS   = SAMPLE_BITS + 2;
  localparam int COEF_BITS   = 16;
  localparam int PROD_BITS   = DIFF_BITS + COEF_BITS + 1;
  localparam int SUM_BITS    = PROD_BITS + 2;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR    = 2;
  localparam int CFG_IDX_BITS = 3;
  localparam logic [EXT_BITS-1:0] SIZE_MAX = EXT_BITS'(MAX_EXTENT - 2);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SIZE_X = 3'd0,
    REG_SIZE_Y = 3'd1,
    REG_SIZE_Z = 3'd2,
    REG_COEF_X = 3'd3,
    REG_COEF_Y = 3'd4,
    REG_COEF_Z = 3'd5
  } reg_idx_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t             c;
    sample_t             xm;
    sample_t             xp;
    sample_t             ym;
    sample_t             yp;
    sample_t             zm;
    sample_t             zp;
    logic [EXT_BITS-1:0] px;
    logic [EXT_BITS-1:0] py;
    logic [EXT_BITS-1:0] pz;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [COEF_BITS-1:0] cx;
    logic [COEF_BITS-1:0] cy;
    logic [COEF_BITS-1:0] cz;
  } coefs_t;

  function automatic logic [EXT_BITS-1:0] clamp_size(input logic [EXT_BITS-1:0] s);
    return (s > SIZE_MAX) ? SIZE_MAX : s;
  endfunction

endpackage

FILE: rtl/core/hsp_front.sv
// Front end: grid position tracking, plane buffer and neighbour fetch.
// Depends on hsp_pkg.
module hsp_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  hsp_pkg::sample_t             in_value,
  input  logic                         in_first,
  input  logic [hsp_pkg::EXT_BITS-1:0] size_x,
  input  logic [hsp_pkg::EXT_BITS-1:0] size_y,
  input  logic [hsp_pkg::EXT_BITS-1:0] size_z,
  output logic                         push,
  output hsp_pkg::item_t               item,
  input  logic                         full
);
  import hsp_pkg::*;

  logic [EXT_BITS-1:0] pos_x, pos_y, pos_z;
  logic [EXT_BITS-1:0] cx, cy, cz, sx, sy, sz, p;
  logic [EXT_BITS:0]   sx1, sy1, sz1;
  logic                accept, interior;
  logic [ADDR_BITS-1:0] wa, a_c, a_ym, a_yp, a_zm, a_zp;

  sample_t mem_a [STORE_WORDS];
  sample_t mem_b [STORE_WORDS];
  sample_t mem_c [STORE_WORDS];

  logic                s1_valid;
  sample_t             r_c, r_xm, r_ym, r_yp, r_zm, r_zp, r_v;
  logic [EXT_BITS-1:0] r_px, r_py, r_pz;
  logic                r_last;

  assign in_ready = !s1_valid || !full;
  assign accept   = in_valid && in_ready;
  assign push     = s1_valid && !full;

  assign sx  = clamp_size(size_x);
  assign sy  = clamp_size(size_y);
  assign sz  = clamp_size(size_z);
  assign sx1 = {1'b0, sx} + 1'b1;
  assign sy1 = {1'b0, sy} + 1'b1;
  assign sz1 = {1'b0, sz} + 1'b1;

  assign cx = in_first ? '0 : pos_x;
  assign cy = in_first ? '0 : pos_y;
  assign cz = in_first ? '0 : pos_z;
  assign p  = cx - 1'b1;

  assign interior = (cx >= EXT_BITS'(2)) && ({1'b0, cx} <= sx1) &&
                    (cy != '0) && (cy <= sy) && (cz != '0) && (cz <= sz);

  assign wa   = {cx[0], cy, cz};
  assign a_c  = {p[0], cy, cz};
  assign a_ym = {p[0], cy - 1'b1, cz};
  assign a_yp = {p[0], cy + 1'b1, cz};
  assign a_zm = {p[0], cy, cz - 1'b1};
  assign a_zp = {p[0], cy, cz + 1'b1};

  always_ff @(posedge clk) begin
    if (accept) begin
      r_c  <= mem_a[a_c];
      r_xm <= mem_a[wa];
      r_ym <= mem_b[a_ym];
      r_yp <= mem_b[a_yp];
      r_zm <= mem_c[a_zm];
      r_zp <= mem_c[a_zp];
      mem_a[wa] <= in_value;
      mem_b[wa] <= in_value;
      mem_c[wa] <= in_value;
      r_v    <= in_value;
      r_px   <= p;
      r_py   <= cy;
      r_pz   <= cz;
      r_last <= (p == sx) && (cy == sy) && (cz == sz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x    <= '0;
      pos_y    <= '0;
      pos_z    <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= interior;
        if ({1'b0, cz} >= sz1) begin
          pos_z <= '0;
          if ({1'b0, cy} >= sy1) begin
            pos_y <= '0;
            pos_x <= ({1'b0, cx} >= sx1) ? '0 : cx + 1'b1;
          end else begin
            pos_y <= cy + 1'b1;
            pos_x <= cx;
          end
        end else begin
          pos_z <= cz + 1'b1;
          pos_y <= cy;
          pos_x <= cx;
        end
      end else if (push) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    item.c    = r_c;
    item.xm   = r_xm;
    item.xp   = r_v;
    item.ym   = r_ym;
    item.yp   = r_yp;
    item.zm   = r_zm;
    item.zp   = r_zp;
    item.px   = r_px;
    item.py   = r_py;
    item.pz   = r_pz;
    item.last = r_last;
  end
endmodule

FILE: rtl/core/hsp_fifo.sv
// Short queue of fetched stencil neighbourhoods between front and back.
// Depends on hsp_pkg.
module hsp_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hsp_pkg::item_t din,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output hsp_pkg::item_t dout
);
  import hsp_pkg::*;

  item_t                store [FIFO_DEPTH];
  logic [FIFO_PTR-1:0]  wp, rp;
  logic [FIFO_PTR:0]    count;

  assign full  = (count == (FIFO_PTR+1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign dout  = store[rp];

  always_ff @(posedge clk) begin
    if (push) store[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule

FILE: rtl/core/hsp_back.sv
// Back end: stencil arithmetic pipeline with saturation and output register.
// Depends on hsp_pkg.
module hsp_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         empty,
  output logic                         pop,
  input  hsp_pkg::item_t               item,
  input  hsp_pkg::coefs_t              coefs,
  output logic                         out_valid,
  input  logic                         out_ready,
  output hsp_pkg::sample_t             out_value,
  output logic [hsp_pkg::EXT_BITS-1:0] out_x,
  output logic [hsp_pkg::EXT_BITS-1:0] out_y,
  output logic [hsp_pkg::EXT_BITS-1:0] out_z,
  output logic                         out_last
);
  import hsp_pkg::*;

  typedef struct packed {
    sample_t             c;
    logic [EXT_BITS-1:0] x;
    logic [EXT_BITS-1:0] y;
    logic [EXT_BITS-1:0] z;
    logic                last;
  } tag_t;

  logic en;
  logic v1, v2, v3;
  tag_t t1, t2, t3;
  logic signed [DIFF_BITS-1:0] d_x, d_y, d_z;
  logic signed [PROD_BITS-1:0] m_x, m_y, m_z;
  logic signed [SUM_BITS-1:0]  sum;
  logic signed [DIFF_BITS-1:0] c2;
  logic signed [SUM_BITS-17:0] sh;
  logic signed [SUM_BITS-16:0] r;
  logic signed [SUM_BITS-16:0] maxv, minv;

  assign en  = !out_valid || out_ready;
  assign pop = !empty && en;
  assign c2  = DIFF_BITS'(item.c) <<< 1;
  assign sh  = sum[SUM_BITS-1:16];
  assign r   = (SUM_BITS-15)'(t3.c) + (SUM_BITS-15)'(sh);
  assign maxv = (SUM_BITS-15)'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  assign minv = -maxv - 1'b1;

  always_ff @(posedge clk) begin
    if (en) begin
      d_x <= DIFF_BITS'(item.xm) + DIFF_BITS'(item.xp) - c2;
      d_y <= DIFF_BITS'(item.ym) + DIFF_BITS'(item.yp) - c2;
      d_z <= DIFF_BITS'(item.zm) + DIFF_BITS'(item.zp) - c2;
      t1  <= '{c: item.c, x: item.px, y: item.py, z: item.pz, last: item.last};
      m_x <= $signed({1'b0, coefs.cx}) * d_x;
      m_y <= $signed({1'b0, coefs.cy}) * d_y;
      m_z <= $signed({1'b0, coefs.cz}) * d_z;
      t2  <= t1;
      sum <= SUM_BITS'(m_x) + SUM_BITS'(m_y) + SUM_BITS'(m_z);
      t3  <= t2;
      if (r > maxv)      out_value <= maxv[SAMPLE_BITS-1:0];
      else if (r < minv) out_value <= minv[SAMPLE_BITS-1:0];
      else               out_value <= r[SAMPLE_BITS-1:0];
      out_x    <= t3.x;
      out_y    <= t3.y;
      out_z    <= t3.z;
      out_last <= t3.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= pop;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end
endmodule

FILE: rtl/core/heat_stencil_7pt_3d.sv
// Top level of the seven-point 3D heat stencil: registers, front, queue, back.
// Depends on hsp_pkg, hsp_front, hsp_fifo, hsp_back.
//
// Takes one grid sample per clock in raster order (halo included) unless the
// output stalls, and emits one updated value for each interior point once its
// x-plus neighbour arrives. Sustained rate is one sample per cycle, set by the
// plane buffer, which is replicated three times so each copy serves two of the
// six neighbour reads per cycle. The buffer is read at the edge that takes the
// sample which completes a point; the result passes the front registers, the
// queue, three arithmetic stages and the output register. The buffer needs no
// clearing pass; the user writes configuration while the block is idle; it is not enforced.
module heat_stencil_7pt_3d (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,   // in_value
  input  logic                              s_tuser,   // in_first
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [55:0]                       m_tdata,   // out_value, out_x, out_y, out_z
  output logic                              m_tlast,   // out_last
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hsp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [15:0]                       cfg_data
);
  import hsp_pkg::*;

  logic [EXT_BITS-1:0] size_x, size_y, size_z;
  coefs_t              coefs;
  logic                push, full, pop, empty;
  item_t               f_item, q_item;
  sample_t             out_value;
  logic [EXT_BITS-1:0] out_x, out_y, out_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_MAX;
      size_y <= SIZE_MAX;
      size_z <= SIZE_MAX;
      coefs  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x   <= cfg_data[EXT_BITS-1:0];
        REG_SIZE_Y: size_y   <= cfg_data[EXT_BITS-1:0];
        REG_SIZE_Z: size_z   <= cfg_data[EXT_BITS-1:0];
        REG_COEF_X: coefs.cx <= cfg_data;
        REG_COEF_Y: coefs.cy <= cfg_data;
        REG_COEF_Z: coefs.cz <= cfg_data;
        default: ;
      endcase
    end
  end

  hsp_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_value(s_tdata), .in_first(s_tuser),
    .size_x(size_x), .size_y(size_y), .size_z(size_z),
    .push(push), .item(f_item), .full(full)
  );

  hsp_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(push), .din(f_item), .full(full),
    .pop(pop), .empty(empty), .dout(q_item)
  );

  hsp_back u_back (
    .clk(clk), .rst(rst),
    .empty(empty), .pop(pop), .item(q_item), .coefs(coefs),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_value(out_value), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_last(m_tlast)
  );

  assign m_tdata = {6'd0, out_z, out_y, out_x, out_value};
endmodule
